FILE: sv/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types and constants for the time-weighted sensor
// average block.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int NUM_CH          = 9;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;
  localparam int ACC_BITS        = 64;
  localparam int TOT_BITS        = 48;
  localparam int OUT_BITS        = 16;
  localparam int TS_BITS         = 32;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIV,
    ST_OUT
  } tws_state_t;

  // Control from the sequencer to the lanes.
  typedef struct packed {
    logic accum;   // add the weighted previous value
    logic load;    // store the current value as previous
    logic clear;   // return accumulator to zero
  } lane_ctrl_t;

endpackage

FILE: sv/tws_if.sv
// ----------------------------------------------------------------------------
// tws_in_if / tws_out_if
// Valid/ready channels carrying one sensor sample and one average result.
// ----------------------------------------------------------------------------
interface tws_in_if;
  logic                valid;
  logic                ready;
  logic [31:0]         timestamp;
  logic signed [15:0]  acl_x, acl_y, acl_z;
  logic signed [15:0]  gyr_x, gyr_y, gyr_z;
  logic signed [15:0]  mag_x, mag_y, mag_z;
  logic                last_sample;
  modport source (output valid, timestamp, acl_x, acl_y, acl_z, gyr_x, gyr_y,
                  gyr_z, mag_x, mag_y, mag_z, last_sample, input ready);
  modport sink   (input valid, timestamp, acl_x, acl_y, acl_z, gyr_x, gyr_y,
                  gyr_z, mag_x, mag_y, mag_z, last_sample, output ready);
endinterface

interface tws_out_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  avg_acl_x, avg_acl_y, avg_acl_z;
  logic signed [15:0]  avg_gyr_x, avg_gyr_y, avg_gyr_z;
  logic signed [15:0]  avg_mag_x, avg_mag_y, avg_mag_z;
  logic                no_weight;
  modport source (output valid, avg_acl_x, avg_acl_y, avg_acl_z, avg_gyr_x,
                  avg_gyr_y, avg_gyr_z, avg_mag_x, avg_mag_y, avg_mag_z,
                  no_weight, input ready);
  modport sink   (input valid, avg_acl_x, avg_acl_y, avg_acl_z, avg_gyr_x,
                  avg_gyr_y, avg_gyr_z, avg_mag_x, avg_mag_y, avg_mag_z,
                  no_weight, output ready);
endinterface

FILE: sv/tws_lane.sv
// ----------------------------------------------------------------------------
// tws_lane
// One channel: previous value, saturating multiply-accumulate by elapsed time.
// ----------------------------------------------------------------------------
module tws_lane #(
  parameter int SAMPLE_BITS = tws_pkg::SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = tws_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tws_pkg::lane_ctrl_t              ctrl,
  input  logic [tws_pkg::OUT_BITS-1:0]     cur_raw,
  input  logic [TIME_BITS-1:0]             dt,
  output logic signed [tws_pkg::ACC_BITS-1:0] acc
);
  import tws_pkg::*;

  localparam int PW = SAMPLE_BITS + TIME_BITS + 1;

  logic signed [SAMPLE_BITS-1:0] prev_r;
  logic signed [ACC_BITS-1:0]    acc_r, acc_nxt;
  logic signed [PW-1:0]          prod;
  logic signed [ACC_BITS-1:0]    prod_sat;
  logic signed [ACC_BITS:0]      sum;
  logic signed [SAMPLE_BITS-1:0] cur_s;

  // Input field is 16 bits; truncate it to SAMPLE_BITS, or sign-extend it when SAMPLE_BITS is wider.
  always_comb begin
    if (SAMPLE_BITS <= OUT_BITS)
      cur_s = SAMPLE_BITS'(cur_raw);
    else
      cur_s = SAMPLE_BITS'($signed(cur_raw));
  end

  assign prod = PW'(prev_r) * $signed({1'b0, dt});

  // Products fit within 64 bits for the default widths; wider ones saturate.
  always_comb begin
    if (PW <= ACC_BITS)
      prod_sat = ACC_BITS'(prod);
    else if (prod > PW'({1'b0, {(ACC_BITS-1){1'b1}}}))
      prod_sat = {1'b0, {(ACC_BITS-1){1'b1}}};
    else if (prod < -PW'({1'b0, {(ACC_BITS-1){1'b1}}}) - PW'(1))
      prod_sat = {1'b1, {(ACC_BITS-1){1'b0}}};
    else
      prod_sat = ACC_BITS'(prod);
  end

  assign sum = (ACC_BITS+1)'(acc_r) + (ACC_BITS+1)'(prod_sat);

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear)
      acc_nxt = '0;
    else if (ctrl.accum) begin
      if (sum[ACC_BITS] != sum[ACC_BITS-1])
        acc_nxt = sum[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                : {1'b0, {(ACC_BITS-1){1'b1}}};
      else
        acc_nxt = sum[ACC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      prev_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      if (ctrl.load) prev_r <= cur_s;
    end
  end

  assign acc = acc_r;
endmodule

FILE: sv/tws_div.sv
// ----------------------------------------------------------------------------
// tws_div
// Shared restoring divider: signed 64-bit dividend by unsigned 48-bit
// divisor, one quotient bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module tws_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [tws_pkg::ACC_BITS-1:0] dividend,
  input  logic [tws_pkg::TOT_BITS-1:0]        divisor,
  output logic                                done,
  output logic signed [tws_pkg::ACC_BITS-1:0] quot
);
  import tws_pkg::*;

  localparam int CW = $clog2(ACC_BITS + 1);

  logic [ACC_BITS-1:0] q_r;
  logic [TOT_BITS:0]   rem_r;
  logic [CW-1:0]       cnt_r;
  logic                busy_r, neg_r, done_r;
  logic [TOT_BITS:0]   shifted;
  logic [TOT_BITS:0]   trial;

  assign shifted = {rem_r[TOT_BITS-1:0], q_r[ACC_BITS-1]};
  assign trial   = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(ACC_BITS);
        neg_r  <= dividend[ACC_BITS-1];
        q_r    <= dividend[ACC_BITS-1] ? ACC_BITS'(-dividend) : dividend;
        rem_r  <= '0;
      end else if (busy_r) begin
        if (trial[TOT_BITS]) begin
          rem_r <= shifted;
          q_r   <= {q_r[ACC_BITS-2:0], 1'b0};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[ACC_BITS-2:0], 1'b1};
        end
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule

FILE: sv/time_weighted_sensor_average.sv
// ----------------------------------------------------------------------------
// time_weighted_sensor_average
// Nine-lane time-weighted average of joined accelerometer, gyroscope and
// magnetometer samples, with one shared divider for the final means.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | handshake
//  in_     | in  | timestamp, 9 x 16b sample, last_sample   | valid/ready
//  out_    | out | 9 x 16b mean, no_weight                  | valid/ready
//
// A sample that is not last is accumulated by the nine lanes in parallel
// and the next request is taken at once.
// A last sample closes the set: each lane in turn is divided by the time sum
// in the shared divider (start, 64 quotient bits, done), then the means are offered.
// A zero time sum, or a set of one sample, skips the divider and the result is valid the next cycle.
// Synchronous active-low reset clears all sums and the previous sample.
// The result holds in the output register until out_ready is seen.
module time_weighted_sensor_average #(
  parameter int SAMPLE_BITS = tws_pkg::SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = tws_pkg::TIME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tws_in_if.sink    in_ch,
  tws_out_if.source out_ch
);
  import tws_pkg::*;

  localparam int LW = $clog2(NUM_CH);

  tws_state_t state_r, state_nxt;
  logic [TIME_BITS-1:0] prev_time_r;
  logic                 have_prev_r;
  logic [TOT_BITS-1:0]  total_r;
  logic [TIME_BITS-1:0] ts, dt;
  logic [TOT_BITS:0]    tot_sum;
  logic                 take;
  lane_ctrl_t           ctrl;
  logic [LW-1:0]        lane_r, lane_nxt;
  logic                 div_start, div_done;
  logic signed [ACC_BITS-1:0] acc [NUM_CH];
  logic signed [ACC_BITS-1:0] quot;
  logic [OUT_BITS-1:0]  cur_raw [NUM_CH];
  logic [OUT_BITS-1:0]  avg_r [NUM_CH];
  logic [OUT_BITS-1:0]  clamped;
  logic                 nw_r;
  logic                 start_r, start_nxt;

  localparam logic signed [ACC_BITS-1:0] HI = ACC_BITS'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
  localparam logic signed [ACC_BITS-1:0] LO = -HI - ACC_BITS'(1);

  assign ts   = TIME_BITS'(in_ch.timestamp);
  assign dt   = ts - prev_time_r;
  assign take = in_ch.valid && in_ch.ready;

  assign cur_raw[0] = in_ch.acl_x;  assign cur_raw[1] = in_ch.acl_y;
  assign cur_raw[2] = in_ch.acl_z;  assign cur_raw[3] = in_ch.gyr_x;
  assign cur_raw[4] = in_ch.gyr_y;  assign cur_raw[5] = in_ch.gyr_z;
  assign cur_raw[6] = in_ch.mag_x;  assign cur_raw[7] = in_ch.mag_y;
  assign cur_raw[8] = in_ch.mag_z;

  // Lane control: accumulate on every taken sample once a previous exists;
  // clear once the last lane result is captured.
  always_comb begin
    ctrl.accum = take && have_prev_r;
    ctrl.load  = take;
    ctrl.clear = 1'b0;
    if (state_r == ST_DIV && state_nxt == ST_OUT) ctrl.clear = 1'b1;
  end

  for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
    tws_lane #(.SAMPLE_BITS(SAMPLE_BITS), .TIME_BITS(TIME_BITS)) u_lane (
      .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .cur_raw(cur_raw[i]),
      .dt(dt), .acc(acc[i]));
  end

  tws_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(acc[lane_r]), .divisor(total_r),
    .done(div_done), .quot(quot));

  assign tot_sum = {1'b0, total_r} + (TOT_BITS+1)'(dt);

  // Clamp the quotient into the signed sample range.
  always_comb begin
    if (quot > HI)      clamped = OUT_BITS'(HI);
    else if (quot < LO) clamped = OUT_BITS'(LO);
    else                clamped = OUT_BITS'(quot);
  end

  // Merge stage sequencer: walk the lanes through the shared divider.
  always_comb begin
    state_nxt    = state_r;
    lane_nxt     = lane_r;
    start_nxt    = 1'b0;
    div_start    = start_r;
    in_ch.ready  = (state_r == ST_ACCUM);
    unique case (state_r)
      ST_ACCUM: begin
        if (take && in_ch.last_sample) begin
          lane_nxt = '0;
          if (have_prev_r && tot_sum != '0) begin
            state_nxt = ST_DIV;
            start_nxt = 1'b1;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (lane_r == LW'(NUM_CH - 1)) begin
            state_nxt = ST_OUT;
          end else begin
            lane_nxt  = lane_r + LW'(1);
            start_nxt = 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (out_ch.ready) state_nxt = ST_ACCUM;
      end
      default: state_nxt = ST_ACCUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCUM;
      lane_r      <= '0;
      start_r     <= 1'b0;
      prev_time_r <= '0;
      have_prev_r <= 1'b0;
      total_r     <= '0;
      nw_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lane_r  <= lane_nxt;
      start_r <= start_nxt;
      if (take) begin
        prev_time_r <= ts;
        if (have_prev_r)
          total_r <= tot_sum[TOT_BITS] ? '1 : tot_sum[TOT_BITS-1:0];
        have_prev_r <= 1'b1;
        if (in_ch.last_sample) begin
          have_prev_r <= 1'b0;
          nw_r <= !(have_prev_r && tot_sum != '0);
        end
      end
      if (ctrl.clear) total_r <= '0;
      if (state_r == ST_ACCUM && take && in_ch.last_sample
          && !(have_prev_r && tot_sum != '0))
        total_r <= '0;
    end
  end

  // Clear the output means whenever a last sample is taken, so sets that skip
  // the divider report zero means; else capture each lane's clamped quotient.
  always_ff @(posedge clk) begin
    if (state_r == ST_ACCUM && take && in_ch.last_sample) begin
      for (int k = 0; k < NUM_CH; k++) avg_r[k] <= '0;
    end else if (state_r == ST_DIV && div_done) begin
      avg_r[lane_r] <= clamped;
    end
  end

  assign out_ch.valid     = (state_r == ST_OUT);
  assign out_ch.avg_acl_x = avg_r[0];
  assign out_ch.avg_acl_y = avg_r[1];
  assign out_ch.avg_acl_z = avg_r[2];
  assign out_ch.avg_gyr_x = avg_r[3];
  assign out_ch.avg_gyr_y = avg_r[4];
  assign out_ch.avg_gyr_z = avg_r[5];
  assign out_ch.avg_mag_x = avg_r[6];
  assign out_ch.avg_mag_y = avg_r[7];
  assign out_ch.avg_mag_z = avg_r[8];
  assign out_ch.no_weight = nw_r;
endmodule

FILE: sv/tws_checker.sv
// ----------------------------------------------------------------------------
// tws_checker
// Port-level checks for the time-weighted sensor average block.
// ----------------------------------------------------------------------------
module tws_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic no_weight,
  input logic [15:0] avg0
);
  // A result holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // No new request while a result waits.
  a_no_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during result");

  // A result follows only a last sample.
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last |=> !out_valid)
    else $error("result without last sample");

  // No-weight results carry a zero acl_x mean.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && no_weight |-> avg0 == 16'd0) else $error("nonzero mean");
endmodule

bind time_weighted_sensor_average tws_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_last(in_ch.last_sample),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .no_weight(out_ch.no_weight), .avg0(out_ch.avg_acl_x));
